FILE: rtl/radix40_text_codec_core_assert.svh
// assertion macros for the radix-40 codec checker
// used by rtc_checker.sv; needs a clock named i_clk and a reset named i_rst_n in scope
`ifndef RADIX40_TEXT_CODEC_CORE_ASSERT_SVH
`define RADIX40_TEXT_CODEC_CORE_ASSERT_SVH

// checked only outside reset
`define RTC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked in every cycle, reset included
`define RTC_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

FILE: rtl/rtc_pkg.sv
// types, codes and digit/character helpers for the radix-40 codec
// no dependencies
`timescale 1ns / 1ps

package rtc_pkg;

    localparam logic [1:0] FMT_TRIPLE   = 2'd0;
    localparam logic [1:0] FMT_SEXTET   = 2'd1;
    localparam logic [1:0] FMT_QUAD     = 2'd2;
    localparam logic [1:0] FMT_QUAD_ALT = 2'd3;

    localparam logic KIND_PACK   = 1'b0;
    localparam logic KIND_UNPACK = 1'b1;

    localparam int unsigned RADIX = 40;

    typedef logic [5:0] t_digit;

    localparam t_digit DIG_DASH  = 6'd36;
    localparam t_digit DIG_SPACE = 6'd37;
    localparam t_digit DIG_DOT   = 6'd38;
    localparam t_digit DIG_OTHER = 6'd39;
    localparam t_digit DIG_LIMIT = 6'd40;

    localparam logic [7:0] CHR_DASH  = 8'h2d;
    localparam logic [7:0] CHR_SPACE = 8'h20;
    localparam logic [7:0] CHR_DOT   = 8'h2e;
    localparam logic [7:0] CHR_QUERY = 8'h3f;
    localparam logic [7:0] CHR_ZERO  = 8'h30;

    typedef logic [11:0][5:0]     t_digits;
    typedef logic [5:0][5:0]      t_q32;
    typedef logic [3:0][2:0][5:0] t_qw;

    typedef struct packed {
        logic    kind;
        t_digits digits;
        t_q32    q32;
        t_qw     qw;
    } t_mid;

    function automatic t_digit char_to_digit(input logic [7:0] ch);
        t_digit d;
        if (ch >= 8'h30 && ch <= 8'h39) begin
            d = 6'(ch - 8'h30);
        end else if (ch >= 8'h61 && ch <= 8'h7a) begin
            d = 6'(ch - 8'h57);
        end else if (ch >= 8'h41 && ch <= 8'h5a) begin
            d = 6'(ch - 8'h37);
        end else if (ch == CHR_DOT) begin
            d = DIG_DOT;
        end else if (ch == CHR_SPACE) begin
            d = DIG_SPACE;
        end else if (ch == CHR_DASH) begin
            d = DIG_DASH;
        end else begin
            d = DIG_OTHER;
        end
        return d;
    endfunction

    function automatic logic [7:0] digit_to_char(input t_digit d);
        logic [7:0] c;
        if (d == DIG_OTHER) begin
            c = CHR_QUERY;
        end else if (d == DIG_DOT) begin
            c = CHR_DOT;
        end else if (d == DIG_SPACE) begin
            c = CHR_SPACE;
        end else if (d == DIG_DASH) begin
            c = CHR_DASH;
        end else if (d < 6'd10) begin
            c = {2'b00, d} + CHR_ZERO;
        end else begin
            c = {2'b00, d} + 8'd55;
        end
        return c;
    endfunction

    // top quotient is at most 41
    function automatic t_digit digit_top(input t_digit q);
        return (q >= DIG_LIMIT) ? 6'(q - DIG_LIMIT) : q;
    endfunction

    // lo - 40*hi is below 40, so six bits of each suffice
    function automatic t_digit digit_low(input t_digit lo, input t_digit hi);
        t_digit h40;
        h40 = 6'(hi * 6'd40);
        return 6'(lo - h40);
    endfunction

endpackage

FILE: rtl/rtc_digit_map.sv
// maps the twelve text characters to radix-40 digits
// depends on rtc_pkg
`timescale 1ns / 1ps

module rtc_digit_map (
    input  logic [63:0]     i_text_low,
    input  logic [31:0]     i_text_high,
    output rtc_pkg::t_digits o_digits
);
    import rtc_pkg::*;

    logic [11:0][7:0] chars;

    assign chars = {i_text_high, i_text_low};

    always_comb begin
        for (int i = 0; i < 12; i++) begin
            o_digits[i] = char_to_digit(chars[i]);
        end
    end

endmodule

FILE: rtl/rtc_quot.sv
// quotients of the code by powers of 40 through reciprocal multiplies
// depends on rtc_pkg
`timescale 1ns / 1ps

module rtc_quot (
    input  logic [63:0]  i_code,
    output rtc_pkg::t_q32 o_q32,
    output rtc_pkg::t_qw  o_qw
);
    import rtc_pkg::*;

    assign o_q32[0] = i_code[5:0];

    // v / 40^k = (v >> 3k) / 5^k
    for (genvar k = 1; k < 6; k++) begin : g_q32
        localparam int N = 32 - 3 * k;
        localparam longint unsigned D = 5 ** k;
        localparam int S = N + $clog2(D);
        localparam logic [63:0] M = ((64'd1 << S) + D - 64'd1) / D;
        logic [63:0] prod;
        assign prod = 64'(i_code[31:3*k]) * M;
        assign o_q32[k] = prod[S+5:S];
    end

    for (genvar j = 0; j < 4; j++) begin : g_word
        assign o_qw[j][0] = i_code[16*j +: 6];
        for (genvar k = 1; k < 3; k++) begin : g_qw
            localparam int N = 16 - 3 * k;
            localparam longint unsigned D = 5 ** k;
            localparam int S = N + $clog2(D);
            localparam logic [31:0] M = 32'(((64'd1 << S) + D - 64'd1) / D);
            logic [31:0] prod;
            assign prod = 32'(i_code[16*j+3*k +: N]) * M;
            assign o_qw[j][k] = prod[S+5:S];
        end
    end

endmodule

FILE: rtl/rtc_assemble.sv
// builds the packed code or the unpacked text from the middle stage
// depends on rtc_pkg
`timescale 1ns / 1ps

module rtc_assemble (
    input  rtc_pkg::t_mid i_mid,
    input  logic [1:0]    i_format,
    output logic [63:0]   o_code_out,
    output logic [63:0]   o_text_low_out,
    output logic [31:0]   o_text_high_out
);
    import rtc_pkg::*;

    logic [3:0][15:0] words;
    logic [31:0]      long_word;
    logic [11:0][7:0] chars;
    logic [63:0]      code;

    always_comb begin
        for (int j = 0; j < 4; j++) begin
            words[j] = 16'(i_mid.digits[3*j])   * 16'(RADIX * RADIX)
                     + 16'(i_mid.digits[3*j+1]) * 16'(RADIX)
                     + 16'(i_mid.digits[3*j+2]);
        end
        long_word = 32'(i_mid.digits[0]) * 32'(RADIX ** 5)
                  + 32'(i_mid.digits[1]) * 32'(RADIX ** 4)
                  + 32'(i_mid.digits[2]) * 32'(RADIX ** 3)
                  + 32'(i_mid.digits[3]) * 32'(RADIX ** 2)
                  + 32'(i_mid.digits[4]) * 32'(RADIX)
                  + 32'(i_mid.digits[5]);
    end

    always_comb begin
        chars = '0;
        code  = '0;
        unique case (i_format) inside
            FMT_TRIPLE: begin
                code     = {48'd0, words[0]};
                chars[0] = digit_to_char(digit_top(i_mid.qw[0][2]));
                chars[1] = digit_to_char(digit_low(i_mid.qw[0][1], i_mid.qw[0][2]));
                chars[2] = digit_to_char(digit_low(i_mid.qw[0][0], i_mid.qw[0][1]));
            end
            FMT_SEXTET: begin
                code     = {32'd0, long_word};
                chars[0] = digit_to_char(digit_top(i_mid.q32[5]));
                for (int p = 1; p < 6; p++) begin
                    chars[p] = digit_to_char(digit_low(i_mid.q32[5-p], i_mid.q32[6-p]));
                end
            end
            FMT_QUAD, FMT_QUAD_ALT: begin
                code = words;
                for (int j = 0; j < 4; j++) begin
                    chars[3*j]   = digit_to_char(digit_top(i_mid.qw[j][2]));
                    chars[3*j+1] = digit_to_char(digit_low(i_mid.qw[j][1], i_mid.qw[j][2]));
                    chars[3*j+2] = digit_to_char(digit_low(i_mid.qw[j][0], i_mid.qw[j][1]));
                end
            end
        endcase
    end

    assign o_code_out      = (i_mid.kind == KIND_PACK) ? code : 64'd0;
    assign o_text_low_out  = (i_mid.kind == KIND_UNPACK) ? chars[7:0] : 64'd0;
    assign o_text_high_out = (i_mid.kind == KIND_UNPACK) ? chars[11:8] : 32'd0;

endmodule

FILE: rtl/radix40_text_codec_core.sv
// radix-40 text codec top level: input register, middle register, result register
// depends on rtc_pkg, rtc_digit_map, rtc_quot, rtc_assemble
// an accepted request passes from the input register through the middle register to the result register and o_valid
// throughput: one request per cycle while o_ready is high; the three-stage register chain moves as a
// pipeline and o_ready drops only when all stages hold requests and i_ready is low
// reset: synchronous, clears all stage valid flags and the format register to 0
`timescale 1ns / 1ps

module radix40_text_codec_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_kind,
    input  logic [63:0] i_text_low,
    input  logic [31:0] i_text_high,
    input  logic [63:0] i_code_in,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [63:0] o_code_out,
    output logic [63:0] o_text_low_out,
    output logic [31:0] o_text_high_out
);
    import rtc_pkg::*;

    logic [1:0]  r_format;
    logic        r_in_valid;
    logic        r_mid_valid;
    logic        r_out_valid;
    logic        r_in_kind;
    logic [63:0] r_in_text_low;
    logic [31:0] r_in_text_high;
    logic [63:0] r_in_code;
    t_mid        r_mid;
    t_mid        n_mid;
    logic [63:0] r_code_out;
    logic [63:0] r_text_low_out;
    logic [31:0] r_text_high_out;
    logic [63:0] n_code_out;
    logic [63:0] n_text_low_out;
    logic [31:0] n_text_high_out;
    logic        out_en;
    logic        mid_en;
    logic        in_en;

    assign out_en  = !r_out_valid || i_ready;
    assign mid_en  = !r_mid_valid || out_en;
    assign in_en   = !r_in_valid || mid_en;
    assign o_ready = in_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_format    <= FMT_TRIPLE;
            r_in_valid  <= 1'b0;
            r_mid_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_format <= i_cfg_data;
            end
            if (in_en) begin
                r_in_valid <= i_valid;
            end
            if (mid_en) begin
                r_mid_valid <= r_in_valid;
            end
            if (out_en) begin
                r_out_valid <= r_mid_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_en && i_valid) begin
            r_in_kind      <= i_kind;
            r_in_text_low  <= i_text_low;
            r_in_text_high <= i_text_high;
            r_in_code      <= i_code_in;
        end
        if (mid_en) begin
            r_mid <= n_mid;
        end
        if (out_en) begin
            r_code_out      <= n_code_out;
            r_text_low_out  <= n_text_low_out;
            r_text_high_out <= n_text_high_out;
        end
    end

    assign n_mid.kind = r_in_kind;

    rtc_digit_map u_digit_map (
        .i_text_low  (r_in_text_low),
        .i_text_high (r_in_text_high),
        .o_digits    (n_mid.digits)
    );

    rtc_quot u_quot (
        .i_code (r_in_code),
        .o_q32  (n_mid.q32),
        .o_qw   (n_mid.qw)
    );

    rtc_assemble u_assemble (
        .i_mid           (r_mid),
        .i_format        (r_format),
        .o_code_out      (n_code_out),
        .o_text_low_out  (n_text_low_out),
        .o_text_high_out (n_text_high_out)
    );

    assign o_valid         = r_out_valid;
    assign o_code_out      = r_code_out;
    assign o_text_low_out  = r_text_low_out;
    assign o_text_high_out = r_text_high_out;

endmodule

FILE: rtl/rtc_checker.sv
// port-level checks for radix40_text_codec_core, attached by bind
// depends on radix40_text_codec_core_assert.svh
`timescale 1ns / 1ps
`include "radix40_text_codec_core_assert.svh"

module rtc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [63:0] o_code_out,
    input logic [63:0] o_text_low_out,
    input logic [31:0] o_text_high_out
);

    // no result straight after reset
    `RTC_ASSERT_ALWAYS(a_reset_clears, !i_rst_n |=> !o_valid, "result valid after reset")

    // stalled result holds
    `RTC_ASSERT(a_stall_hold, o_valid && !i_ready |=> o_valid && $stable(o_code_out) && $stable(o_text_low_out) && $stable(o_text_high_out), "stalled result changed")

    // a result is either a code or text, never both
    `RTC_ASSERT(a_one_kind, o_valid |-> (o_code_out == 64'd0) || (o_text_low_out == 64'd0 && o_text_high_out == 32'd0), "code and text both nonzero")

    // an empty output stage never blocks the input
    `RTC_ASSERT_ALWAYS(a_empty_ready, !o_valid |-> o_ready, "input blocked with empty output")

endmodule

bind radix40_text_codec_core rtc_checker u_rtc_checker (.*);
